// File: design/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

// File: design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and the precedence rule shared by the converter modules.
// ----------------------------------------------------------------------------
package itp_pkg;

    // Token kinds on the input channel.
    localparam logic [1:0] MODE_NUM  = 2'd0;
    localparam logic [1:0] MODE_OP   = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // Operator and parenthesis codes.
    localparam logic [2:0] OP_OPEN  = 3'd0;
    localparam logic [2:0] OP_POW   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_ADD   = 3'd4;
    localparam logic [2:0] OP_SUB   = 3'd5;
    localparam logic [2:0] OP_CLOSE = 3'd6;
    localparam logic [2:0] OP_RSVD  = 3'd7;

    // Result kinds.
    localparam logic [1:0] KIND_NUM  = 2'd0;
    localparam logic [1:0] KIND_OP   = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PAREN    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    localparam int unsigned OP_W  = 3;
    localparam int unsigned VAL_W = 32;

    // One input token.
    typedef struct packed {
        logic [1:0]       mode;
        logic [OP_W-1:0]  op_code;
        logic [VAL_W-1:0] number_value;
    } token_t;

    // One output result.
    typedef struct packed {
        logic [1:0]       out_kind;
        logic [OP_W-1:0]  out_op;
        logic [VAL_W-1:0] out_value;
        logic [1:0]       error_code;
        logic             last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       tok_load;
        logic       rd_below;
        logic       pop;
        logic       push;
        logic       err_set;
        logic [1:0] err_code;
        logic       clear;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_err;
        logic       emit_last;
    } itp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0]      tok_mode;
        logic [OP_W-1:0] tok_op;
        logic [1:0]      err_code;
        logic            count_zero;
        logic            count_one;
        logic            stack_full;
        logic            top_is_open;
        logic            pops_top;
        logic            below_is_open;
        logic            pops_below;
        logic            out_free;
    } itp_sts_t;

    // True when stacked operator top leaves the stack before incoming cur.
    function automatic logic pops_before(input logic [OP_W-1:0] top,
                                         input logic [OP_W-1:0] cur);
        logic res;
        res = 1'b0;
        if (top inside {OP_POW, OP_MUL, OP_DIV}) begin
            res = (cur inside {[OP_MUL:OP_CLOSE]});
        end else if (top inside {OP_ADD, OP_SUB}) begin
            res = (cur inside {[OP_ADD:OP_CLOSE]});
        end
        return res;
    endfunction

endpackage

// File: design/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from infix tokens to a postfix result stream.
// ----------------------------------------------------------------------------
// Usage: tokens arrive on the s_ channel (valid/ready), one per transaction:
// a number, an operator or parenthesis, or an end marker. Results leave on
// the m_ channel (valid/ready) in postfix order; the field last marks the
// final result caused by a token, and a token may cause none at all.
// Timing: a token is taken into the token register in ST_IDLE and decoded in
// the next cycle in ST_EXEC. Each operator popped off the stack passes through
// ST_EXEC and ST_POP, which waits for the registered read of the stack RAM
// that fetches the entry below the cached top.
// One token is worked on at a time; s_ready is high only between tokens.
// Results sit in an output register, so the next token may be taken while
// the last result still waits. If the receiver stalls, the converter waits
// with its next result and does not drop anything.
// Reset (aresetn low, synchronous) empties the stack, clears the error flag
// and the valid flag of the output register. Stack entries need no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  token_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    itp_cmd_t cmd;
    itp_sts_t sts;

    // Controller.
    itp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Datapath.
    itp_datapath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .m_data (m_data),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

// File: design/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int unsigned WIDTH = 3,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// Controller state machine: decodes each token and sequences pops and pushes.
// ----------------------------------------------------------------------------
module itp_ctrl
    import itp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  itp_sts_t sts,
    output itp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.tok_load = 1'b1;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (sts.tok_mode == MODE_END) begin
                    if (sts.err_code != ERR_NONE) begin
                        // A pending error is reported once and the state cleared.
                        if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_ERR;
                            cmd.emit_err  = sts.err_code;
                            cmd.emit_last = 1'b1;
                            cmd.clear     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end else if (sts.count_zero) begin
                        if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = KIND_DONE;
                            cmd.emit_last = 1'b1;
                            cmd.clear     = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end else begin
                        cmd.rd_below = 1'b1;
                        state_next   = ST_POP;
                    end
                end else if (sts.err_code != ERR_NONE || sts.tok_mode == MODE_RSVD) begin
                    // Dropped after an error, or an unused token kind.
                    state_next = ST_IDLE;
                end else if (sts.tok_mode == MODE_NUM) begin
                    if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_NUM;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (sts.tok_op == OP_CLOSE) begin
                    if (sts.count_zero) begin
                        cmd.err_set  = 1'b1;
                        cmd.err_code = ERR_PAREN;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.rd_below = 1'b1;
                        state_next   = ST_POP;
                    end
                end else if (sts.tok_op == OP_RSVD) begin
                    state_next = ST_IDLE;
                end else if (!sts.count_zero && sts.tok_op != OP_OPEN && sts.pops_top) begin
                    cmd.rd_below = 1'b1;
                    state_next   = ST_POP;
                end else if (sts.stack_full) begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ERR_OVERFLOW;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_POP: begin
                // The entry below the top is now in the RAM read register.
                if (sts.tok_mode == MODE_END) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        if (sts.top_is_open) begin
                            cmd.emit_kind = KIND_ERR;
                            cmd.emit_err  = ERR_PAREN;
                            cmd.emit_last = 1'b1;
                            cmd.clear     = 1'b1;
                            state_next    = ST_IDLE;
                        end else begin
                            cmd.emit_kind = KIND_OP;
                            cmd.pop       = 1'b1;
                            state_next    = ST_EXEC;
                        end
                    end
                end else if (sts.tok_op == OP_CLOSE) begin
                    if (sts.top_is_open) begin
                        cmd.pop    = 1'b1;
                        state_next = ST_IDLE;
                    end else if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_OP;
                        cmd.emit_last = sts.count_one || sts.below_is_open;
                        cmd.pop       = 1'b1;
                        state_next    = ST_EXEC;
                    end
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_OP;
                    cmd.emit_last = sts.count_one || !sts.pops_below;
                    cmd.pop       = 1'b1;
                    state_next    = ST_EXEC;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath
// Token register, operator stack with cached top, error flag and result register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module itp_datapath
    import itp_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  token_t   s_data,
    input  logic     m_ready,
    output logic     m_valid,
    output result_t  m_data,
    input  itp_cmd_t cmd,
    output itp_sts_t sts
);

    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    token_t            tok_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OP_W-1:0]   top_reg, top_next;
    logic [1:0]        err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [OP_W-1:0]   below_data;
    logic [CNT_W-1:0]  below_idx;
    logic              out_free;

    // Stack storage below the cached top.
    assign below_idx = count_reg - CNT_W'(2);

    itp_ram #(
        .WIDTH(OP_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (cmd.push),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(tok_reg.op_code),
        .re   (cmd.rd_below),
        .raddr(below_idx[ADDR_W-1:0]),
        .rdata(below_data)
    );

    assign out_free = !out_valid_reg || m_ready;

    // Status back to the controller.
    always_comb begin
        sts               = '0;
        sts.tok_mode      = tok_reg.mode;
        sts.tok_op        = tok_reg.op_code;
        sts.err_code      = err_reg;
        sts.count_zero    = (count_reg == '0);
        sts.count_one     = (count_reg == CNT_W'(1));
        sts.stack_full    = (count_reg == CNT_W'(STACK_DEPTH));
        sts.top_is_open   = (top_reg == OP_OPEN);
        sts.pops_top      = pops_before(top_reg, tok_reg.op_code);
        sts.below_is_open = (below_data == OP_OPEN);
        sts.pops_below    = pops_before(below_data, tok_reg.op_code);
        sts.out_free      = out_free;
    end

    // Stack pointer, cached top and error flag.
    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        err_next   = err_reg;
        if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
            top_next   = below_data;
        end
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
            top_next   = tok_reg.op_code;
        end
        if (cmd.err_set) begin
            err_next = cmd.err_code;
        end
        if (cmd.clear) begin
            count_next = '0;
            err_next   = ERR_NONE;
        end
    end

    // Result register; loaded only when the previous transaction has left.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next      = 1'b1;
            out_next.out_kind   = cmd.emit_kind;
            out_next.out_op     = (cmd.emit_kind == KIND_OP) ? top_reg : OP_OPEN;
            out_next.out_value  = (cmd.emit_kind == KIND_NUM) ? tok_reg.number_value
                                                              : '0;
            out_next.error_code = (cmd.emit_kind == KIND_ERR) ? cmd.emit_err : ERR_NONE;
            out_next.last       = cmd.emit_last;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        out_reg <= out_next;
        if (cmd.tok_load) begin
            tok_reg <= s_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Checks on the stack and result register.
    `ITP_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `ITP_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, cmd.pop, count_reg != '0)
    `ITP_ASSERT_NOW(a_push_room, aclk, aresetn, cmd.push, !cmd.pop && !sts.stack_full)
    `ITP_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, out_free)
    `ITP_ASSERT_NEXT(a_err_code, aclk, aresetn, cmd.emit && cmd.emit_kind == KIND_ERR,
                     m_data.error_code != ERR_NONE)

endmodule

// File: test/infix_to_postfix_converter_test.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// Self-checking testbench for the shunting-yard converter. Token transactions
// are offered from a queue of pending tokens, every accepted token is run
// through a behavioural converter that predicts the postfix results, and each
// result transaction is checked field by field against the oldest prediction.
// Stimulus is a short directed sequence followed by random expressions, with
// random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_test
    import itp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STACK_DEPTH = 32;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    token_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    // Tokens waiting to be offered, and postfix results still to arrive.
    token_t  token_q[$];
    result_t postfix_q[$];

    // Behavioural copy of the operator stack and the error flag.
    logic [OP_W-1:0] op_stack_m[STACK_DEPTH];
    int              depth_m = 0;
    logic [1:0]      err_m   = ERR_NONE;

    int mismatches   = 0;
    int items_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold      = 1'b0;
    bit tok_taken    = 1'b0;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Binding strength of an operator; a closing parenthesis binds weakest.
    function automatic int rank(logic [OP_W-1:0] op);
        case (op)
            OP_POW:         return 3;
            OP_MUL, OP_DIV: return 2;
            OP_ADD, OP_SUB: return 1;
            default:        return 0;
        endcase
    endfunction

    // True when the stacked operator must be emitted before the incoming one.
    // Equal strength pops, except for the right-associative power operator.
    function automatic bit leaves_before(logic [OP_W-1:0] top, logic [OP_W-1:0] cur);
        if (top == OP_OPEN) begin
            return 1'b0;
        end
        if (rank(top) > rank(cur)) begin
            return 1'b1;
        end
        return (rank(top) == rank(cur)) && (cur != OP_POW);
    endfunction

    function automatic result_t make_result(logic [1:0] kind, logic [OP_W-1:0] op,
                                            logic [VAL_W-1:0] value, logic [1:0] err);
        result_t r;
        r.out_kind   = kind;
        r.out_op     = op;
        r.out_value  = value;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    // Works out the postfix results of one accepted token and queues them.
    function automatic void convert_token(token_t tok);
        result_t         batch[$];
        logic [OP_W-1:0] top;
        bit              found;
        found = 1'b0;
        if (tok.mode == MODE_END) begin
            if (err_m != ERR_NONE) begin
                batch.push_back(make_result(KIND_ERR, '0, '0, err_m));
            end else begin
                // Flush the stack top first; an opening parenthesis is left over.
                while (depth_m > 0) begin
                    top = op_stack_m[depth_m-1];
                    depth_m--;
                    if (top == OP_OPEN) begin
                        found = 1'b1;
                        break;
                    end
                    batch.push_back(make_result(KIND_OP, top, '0, ERR_NONE));
                end
                if (found) begin
                    batch.push_back(make_result(KIND_ERR, '0, '0, ERR_PAREN));
                end else begin
                    batch.push_back(make_result(KIND_DONE, '0, '0, ERR_NONE));
                end
            end
            depth_m = 0;
            err_m   = ERR_NONE;
        end else if (err_m != ERR_NONE || tok.mode == MODE_RSVD) begin
            // Dropped while an error is pending, or a reserved token kind.
        end else if (tok.mode == MODE_NUM) begin
            batch.push_back(make_result(KIND_NUM, '0, tok.number_value, ERR_NONE));
        end else if (tok.op_code == OP_CLOSE) begin
            // Pop down to the matching opening parenthesis.
            while (depth_m > 0) begin
                top = op_stack_m[depth_m-1];
                depth_m--;
                if (top == OP_OPEN) begin
                    found = 1'b1;
                    break;
                end
                batch.push_back(make_result(KIND_OP, top, '0, ERR_NONE));
            end
            if (!found) begin
                err_m = ERR_PAREN;
            end
        end else if (tok.op_code != OP_RSVD) begin
            if (tok.op_code != OP_OPEN) begin
                while (depth_m > 0 && leaves_before(op_stack_m[depth_m-1], tok.op_code)) begin
                    batch.push_back(make_result(KIND_OP, op_stack_m[depth_m-1], '0, ERR_NONE));
                    depth_m--;
                end
            end
            if (depth_m >= STACK_DEPTH) begin
                err_m = ERR_OVERFLOW;
            end else begin
                op_stack_m[depth_m] = tok.op_code;
                depth_m++;
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size()-1].last = 1'b1;
        end
        foreach (batch[i]) begin
            postfix_q.push_back(batch[i]);
        end
    endfunction

    // Input sampling, result checking and prediction, all at the rising edge.
    always @(posedge aclk) begin
        result_t want;
        tok_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (postfix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result kind %0d op %0d value %h err %0d last %0d",
                             $realtime, m_data.out_kind, m_data.out_op, m_data.out_value,
                             m_data.error_code, m_data.last);
                end
            end else begin
                want = postfix_q.pop_front();
                if (m_data.out_kind !== want.out_kind || m_data.out_op !== want.out_op ||
                    m_data.out_value !== want.out_value ||
                    m_data.error_code !== want.error_code || m_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected kind %0d op %0d value %h err %0d last %0d",
                                 $realtime, want.out_kind, want.out_op, want.out_value,
                                 want.error_code, want.last);
                        $display("%0t:      got kind %0d op %0d value %h err %0d last %0d",
                                 $realtime, m_data.out_kind, m_data.out_op, m_data.out_value,
                                 m_data.error_code, m_data.last);
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            convert_token(s_data);
        end
    end

    // Token driver: a transaction is held until accepted, then the next one
    // is offered unless the sender idles this cycle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tok_taken) begin
            if (token_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= token_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls and the long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic token_t make_tok(logic [1:0] mode, logic [OP_W-1:0] op,
                                        logic [VAL_W-1:0] value);
        token_t t;
        t.mode         = mode;
        t.op_code      = op;
        t.number_value = value;
        return t;
    endfunction

    // Queues a token; reserved kinds are not counted as real items.
    function automatic void add(token_t t);
        token_q.push_back(t);
        if (!(t.mode == MODE_RSVD || (t.mode == MODE_OP && t.op_code == OP_RSVD))) begin
            items_sent++;
        end
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // A chain of power operators: nothing pops, so the end marker flushes them
    // all. Thirty-two of them give the largest burst of results; one more
    // overflows the stack.
    function automatic void add_deep_chain(int n);
        add(make_tok(MODE_NUM, OP_OPEN, rand_value()));
        repeat (n) begin
            add(make_tok(MODE_OP, OP_POW, $urandom));
            add(make_tok(MODE_NUM, OP_OPEN, rand_value()));
        end
        add(make_tok(MODE_END, OP_OPEN, $urandom));
    endfunction

    // Deep nesting of opening parentheses, closed in part, in full or not at all.
    function automatic void add_nesting(int k);
        repeat (k) add(make_tok(MODE_OP, OP_OPEN, $urandom));
        add(make_tok(MODE_NUM, OP_OPEN, rand_value()));
        repeat ($urandom_range(k)) add(make_tok(MODE_OP, OP_CLOSE, $urandom));
        add(make_tok(MODE_END, OP_OPEN, $urandom));
    endfunction

    // One random expression: mostly well formed, sometimes with a stray
    // token, a leftover or an unmatched parenthesis.
    function automatic void add_expression();
        int style;
        int open_cnt;
        int terms;
        int tail;
        style = $urandom_range(99);
        if (style < 5) begin
            add_deep_chain($urandom_range(29, 33));
            return;
        end
        if (style < 9) begin
            add_nesting($urandom_range(30, 34));
            return;
        end
        open_cnt = 0;
        terms    = $urandom_range(1, 10);
        while (terms > 0) begin
            while (open_cnt < 8 && $urandom_range(3) == 0) begin
                add(make_tok(MODE_OP, OP_OPEN, $urandom));
                open_cnt++;
            end
            add(make_tok(MODE_NUM, 3'($urandom), rand_value()));
            terms--;
            while (open_cnt > 0 && $urandom_range(2) == 0) begin
                add(make_tok(MODE_OP, OP_CLOSE, $urandom));
                open_cnt--;
            end
            if (terms > 0) begin
                add(make_tok(MODE_OP, 3'($urandom_range(OP_POW, OP_SUB)), $urandom));
            end
            if ($urandom_range(39) == 0) begin
                add(make_tok(2'($urandom), 3'($urandom), $urandom));
            end
        end
        tail = $urandom_range(9);
        if (tail != 0) begin
            repeat (open_cnt) add(make_tok(MODE_OP, OP_CLOSE, $urandom));
        end
        if (tail == 1) begin
            add(make_tok(MODE_OP, OP_CLOSE, $urandom));
        end
        add(make_tok(MODE_END, OP_OPEN, $urandom));
    endfunction

    // Sender pause: waits until every queued token has gone and every
    // predicted result has arrived, then returns just after a rising edge.
    task automatic drain();
        do @(negedge aclk);
        while (token_q.size() != 0 || s_valid || postfix_q.size() != 0);
        @(posedge aclk);
    endtask

    // Reset, stimulus phases and the final verdict.
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // Directed part, with no idling. An empty expression first.
        add(make_tok(MODE_END, OP_OPEN, '0));
        // 0 ^ ~0 ^ 2 * 3 - ( 1 + 2 / 3 ), with reserved tokens mixed in.
        add(make_tok(MODE_NUM, OP_OPEN, '0));
        add(make_tok(MODE_OP, OP_POW, '0));
        add(make_tok(MODE_NUM, OP_RSVD, '1));
        add(make_tok(MODE_RSVD, OP_RSVD, '1));
        add(make_tok(MODE_OP, OP_POW, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd2));
        add(make_tok(MODE_OP, OP_MUL, '0));
        add(make_tok(MODE_OP, OP_RSVD, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd3));
        add(make_tok(MODE_OP, OP_SUB, '0));
        add(make_tok(MODE_OP, OP_OPEN, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd1));
        add(make_tok(MODE_OP, OP_ADD, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd2));
        add(make_tok(MODE_OP, OP_DIV, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd3));
        add(make_tok(MODE_OP, OP_CLOSE, '0));
        add(make_tok(MODE_END, OP_OPEN, '0));
        // Unmatched closing parenthesis; the number after it is dropped.
        add(make_tok(MODE_NUM, OP_OPEN, 32'h5555_5555));
        add(make_tok(MODE_OP, OP_ADD, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'hAAAA_AAAA));
        add(make_tok(MODE_OP, OP_CLOSE, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd9));
        add(make_tok(MODE_END, OP_OPEN, '0));
        // Opening parenthesis left over at the end, an operator above it.
        add(make_tok(MODE_OP, OP_OPEN, '0));
        add(make_tok(MODE_NUM, OP_OPEN, 32'd4));
        add(make_tok(MODE_OP, OP_MUL, '0));
        add(make_tok(MODE_END, OP_OPEN, '0));
        // Largest burst of results, then a stack overflow.
        add_deep_chain(STACK_DEPTH);
        add_nesting(STACK_DEPTH + 1);

        // Number transactions that keep arriving while the receiver holds off,
        // so the converter fills up and stops taking tokens.
        repeat (20) add(make_tok(MODE_NUM, 3'($urandom), $urandom));
        rx_hold = 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold = 1'b0;
        while (items_sent < 130) add_expression();
        drain();

        // Sender idle most of the time.
        tx_idle_pct = 87;
        while (items_sent < 220) add_expression();
        drain();

        // Receiver stalling most of the time.
        tx_idle_pct  = 0;
        rx_stall_pct = 87;
        while (items_sent < 320) add_expression();
        drain();

        // Light idling on both sides.
        tx_idle_pct  = 13;
        rx_stall_pct = 13;
        while (items_sent < 405) add_expression();
        drain();

        repeat (100) @(posedge aclk);
        if (mismatches == 0 && postfix_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/itp_pkg.sv
design/itp_ram.sv
design/itp_ctrl.sv
design/itp_datapath.sv
design/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_test.sv
